// ----- rtl/hbpwm_pkg.sv -----
// shared types and constants for the dual h-bridge pwm compare calculator
package hbpwm_pkg;

  localparam int DutyW    = 16;
  localparam int MagW     = 15;
  localparam int FreqW    = 16;
  localparam int PeriodW  = 16;
  localparam int ClockW   = 24;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 24;
  localparam int DivSteps = ClockW;
  localparam int DivCntW  = $clog2(DivSteps);
  localparam int MulSteps = MagW;
  localparam int MulCntW  = $clog2(MulSteps);

  localparam logic [PeriodW-1:0] ResetPeriod   = 16'd40000;
  localparam logic [MagW-1:0]    ResetMaxDuty  = 15'd32767;
  localparam logic [FreqW-1:0]   ResetMinFreq  = 16'd62;
  localparam logic [FreqW-1:0]   ResetMaxFreq  = 16'd20000;
  localparam logic [ClockW-1:0]  ResetTimerClk = 24'd4000000;

  typedef enum logic [1:0] {
    FUNC_DUTY  = 2'd0,
    FUNC_BRAKE = 2'd1,
    FUNC_SHIFT = 2'd2,
    FUNC_APPLY = 2'd3
  } func_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_DUTY  = 2'd0,
    CFG_MIN_FREQ  = 2'd1,
    CFG_MAX_FREQ  = 2'd2,
    CFG_TIMER_CLK = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    func_t              func;
    logic [1:0]         motor;
    logic [DutyW-1:0]   duty;
    logic [FreqW-1:0]   freq;
  } cmd_t;

endpackage

// ----- rtl/hbpwm_div.sv -----
// bit-serial restoring divider for the period count, saturating to 16 bits
module hbpwm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [hbpwm_pkg::ClockW-1:0]  dividend,
  input  logic [hbpwm_pkg::FreqW-1:0]   divisor,
  output logic                          done,
  output logic [hbpwm_pkg::PeriodW-1:0] quotient
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [hbpwm_pkg::DivCntW-1:0] cnt_r, cnt_nxt;
  logic [hbpwm_pkg::FreqW-1:0]   rem_r, rem_nxt;
  logic [hbpwm_pkg::ClockW-1:0]  quo_r, quo_nxt;
  logic [hbpwm_pkg::FreqW-1:0]   dsr_r, dsr_nxt;
  logic [hbpwm_pkg::FreqW:0]     trial;
  logic                          fits;

  // one quotient bit per cycle, msb first
  assign trial = {rem_r, quo_r[hbpwm_pkg::ClockW-1]};
  assign fits  = (trial >= {1'b0, dsr_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? 16'(trial - {1'b0, dsr_r}) : trial[hbpwm_pkg::FreqW-1:0];
      quo_nxt = {quo_r[hbpwm_pkg::ClockW-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == hbpwm_pkg::DivCntW'(hbpwm_pkg::DivSteps - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = (|quo_r[hbpwm_pkg::ClockW-1:hbpwm_pkg::PeriodW]) ?
                    '1 : quo_r[hbpwm_pkg::PeriodW-1:0];

endmodule

// ----- rtl/hbpwm_mul.sv -----
// bit-serial shift-add multiplier giving (period * magnitude) >> 15
module hbpwm_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [hbpwm_pkg::PeriodW-1:0] period,
  input  logic [hbpwm_pkg::MagW-1:0]    mag,
  output logic                          done,
  output logic [hbpwm_pkg::PeriodW-1:0] compare
);

  localparam int AccW = hbpwm_pkg::PeriodW + hbpwm_pkg::MagW;

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [hbpwm_pkg::MulCntW-1:0] cnt_r, cnt_nxt;
  logic [AccW-1:0]               acc_r, acc_nxt;
  logic [hbpwm_pkg::MagW-1:0]    mag_r, mag_nxt;
  logic [hbpwm_pkg::PeriodW-1:0] per_r, per_nxt;
  logic [hbpwm_pkg::PeriodW:0]   sum;

  // add into the upper half, then shift right one place per multiplier bit
  assign sum = {1'b0, acc_r[AccW-1:hbpwm_pkg::MagW]} +
               (mag_r[0] ? {1'b0, per_r} : '0);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    mag_nxt  = mag_r;
    per_nxt  = per_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      mag_nxt  = mag;
      per_nxt  = period;
    end else if (busy_r) begin
      acc_nxt = {sum, acc_r[hbpwm_pkg::MagW-1:1]};
      mag_nxt = mag_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == hbpwm_pkg::MulCntW'(hbpwm_pkg::MulSteps - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mag_r <= mag_nxt;
    per_r <= per_nxt;
  end

  assign done    = done_r;
  assign compare = acc_r[AccW-1:hbpwm_pkg::MagW];

endmodule

// ----- rtl/dual_hbridge_pwm_compare_calc.sv -----
// top level: command sequencer, shadow and live registers, output register
//
// usage
//   input channel: one command per transfer; func and motor in in_tuser, duty and
//   frequency in in_tdata. set duty and brake update the shadow compares of one
//   motor, shift frequency recomputes that motor's period and compares, apply
//   copies both motors' shadow registers to the live registers
//   result channel: one transfer per command, status flag in out_tuser and the six
//   live registers in out_tdata; configuration: cfg_wr_en writes register cfg_addr
//   with cfg_wdata; the user must write only while no command is in work (not enforced)
// sequence
//   set duty and brake pass decode, 15 multiply steps and a hand-over to the done
//   state; shift frequency first runs 24 divide steps and one more hand-over; apply
//   and ignored or refused commands go from decode straight to the done state;
//   in_tready is high only while idle, so the next command is taken only once the
//   last result has been loaded into the output register
// reset: rst_n (synchronous) restores register defaults, a 40000-count period, zero
//   compares and duties, and empties the result register
// stalls: a finished result waits in the output register; the next command is still
//   taken and its result waits in the done state until the register frees up
module dual_hbridge_pwm_compare_calc (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_wr_en,
  input  logic [hbpwm_pkg::CfgIdxW-1:0]  cfg_addr,
  input  logic [hbpwm_pkg::CfgDataW-1:0] cfg_wdata,
  // command channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,  // duty[15:0], frequency[31:16]
  input  logic [3:0]                     in_tuser,  // func[1:0], motor[3:2]
  // result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [95:0]                    out_tdata, // m1_fwd_compare, m1_rev_compare,
                                                    // m1_period, m2_fwd_compare,
                                                    // m2_rev_compare, m2_period
  output logic                           out_tuser  // status
);

  localparam int PW = hbpwm_pkg::PeriodW;

  // configuration registers
  logic [hbpwm_pkg::MagW-1:0]   max_duty_r;
  logic [hbpwm_pkg::FreqW-1:0]  min_freq_r;
  logic [hbpwm_pkg::FreqW-1:0]  max_freq_r;
  logic [hbpwm_pkg::ClockW-1:0] timer_clk_r;

  // per-motor state
  logic [hbpwm_pkg::DutyW-1:0] saved_duty_r [2], saved_duty_nxt [2];
  logic                        brake_flag_r [2], brake_flag_nxt [2];
  logic [PW-1:0]               sh_period_r [2], sh_period_nxt [2];
  logic [PW-1:0]               sh_fwd_r [2], sh_fwd_nxt [2];
  logic [PW-1:0]               sh_rev_r [2], sh_rev_nxt [2];
  logic [PW-1:0]               lv_period_r [2], lv_period_nxt [2];
  logic [PW-1:0]               lv_fwd_r [2], lv_fwd_nxt [2];
  logic [PW-1:0]               lv_rev_r [2], lv_rev_nxt [2];

  hbpwm_pkg::state_t state_r, state_nxt;
  hbpwm_pkg::cmd_t   cmd_r, cmd_nxt;
  logic              status_r, status_nxt;
  logic [hbpwm_pkg::DutyW-1:0] raw_r, raw_nxt;  // duty held while multiplying
  logic              brk_r, brk_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [95:0]       out_data_r, out_data_nxt;
  logic              out_stat_r, out_stat_nxt;

  // command decode
  logic motor_ok;
  logic m;
  logic freq_bad;

  assign motor_ok = (cmd_r.motor == 2'd1) || (cmd_r.motor == 2'd2);
  assign m        = cmd_r.motor[1];
  assign freq_bad = (cmd_r.freq == '0) || (cmd_r.freq < min_freq_r) ||
                    (cmd_r.freq > max_freq_r) || !motor_ok;

  // serial units
  logic          div_start, div_done;
  logic [PW-1:0] div_q;
  logic          mul_start, mul_done;
  logic [PW-1:0] mul_period, mul_c;
  logic [hbpwm_pkg::DutyW-1:0] raw_sel;
  logic          brk_sel;
  logic [16:0]   mag_full;
  logic [hbpwm_pkg::MagW-1:0] mag_lim;

  // magnitude: brake takes negative as zero, set duty takes the absolute value, both capped at max duty
  always_comb begin
    if (brk_sel) begin
      mag_full = raw_sel[15] ? 17'd0 : {1'b0, raw_sel};
    end else if (raw_sel[15]) begin
      mag_full = 17'h10000 - {1'b0, raw_sel};
    end else begin
      mag_full = {1'b0, raw_sel};
    end
    mag_lim = (mag_full > {2'b00, max_duty_r}) ? max_duty_r : mag_full[hbpwm_pkg::MagW-1:0];
  end

  hbpwm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (timer_clk_r),
    .divisor  (cmd_r.freq),
    .done     (div_done),
    .quotient (div_q)
  );

  hbpwm_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .period  (mul_period),
    .mag     (mag_lim),
    .done    (mul_done),
    .compare (mul_c)
  );

  assign in_tready = (state_r == hbpwm_pkg::ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    status_nxt     = status_r;
    raw_nxt        = raw_r;
    brk_nxt        = brk_r;
    saved_duty_nxt = saved_duty_r;
    brake_flag_nxt = brake_flag_r;
    sh_period_nxt  = sh_period_r;
    sh_fwd_nxt     = sh_fwd_r;
    sh_rev_nxt     = sh_rev_r;
    lv_period_nxt  = lv_period_r;
    lv_fwd_nxt     = lv_fwd_r;
    lv_rev_nxt     = lv_rev_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_stat_nxt   = out_stat_r;
    div_start      = 1'b0;
    mul_start      = 1'b0;
    raw_sel        = cmd_r.duty;
    brk_sel        = (cmd_r.func == hbpwm_pkg::FUNC_BRAKE);
    mul_period     = sh_period_r[m];

    case (state_r)
      hbpwm_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt.func  = hbpwm_pkg::func_t'(in_tuser[1:0]);
          cmd_nxt.motor = in_tuser[3:2];
          cmd_nxt.duty  = in_tdata[15:0];
          cmd_nxt.freq  = in_tdata[31:16];
          state_nxt     = hbpwm_pkg::ST_EXEC;
        end
      end
      hbpwm_pkg::ST_EXEC: begin
        status_nxt = 1'b0;
        state_nxt  = hbpwm_pkg::ST_DONE;
        case (cmd_r.func)
          hbpwm_pkg::FUNC_DUTY, hbpwm_pkg::FUNC_BRAKE: begin
            if (motor_ok) begin
              mul_start = 1'b1;
              raw_nxt   = raw_sel;
              brk_nxt   = brk_sel;
              state_nxt = hbpwm_pkg::ST_MUL;
            end
          end
          hbpwm_pkg::FUNC_SHIFT: begin
            if (freq_bad) begin
              status_nxt = 1'b1;
            end else begin
              div_start = 1'b1;
              state_nxt = hbpwm_pkg::ST_DIV;
            end
          end
          hbpwm_pkg::FUNC_APPLY: begin
            lv_period_nxt = sh_period_r;
            lv_fwd_nxt    = sh_fwd_r;
            lv_rev_nxt    = sh_rev_r;
          end
          default: ;
        endcase
      end
      hbpwm_pkg::ST_DIV: begin
        // new period, then recompute with the motor's own saved duty and brake flag
        raw_sel    = saved_duty_r[m];
        brk_sel    = brake_flag_r[m];
        mul_period = div_q;
        if (div_done) begin
          sh_period_nxt[m] = div_q;
          mul_start        = 1'b1;
          raw_nxt          = raw_sel;
          brk_nxt          = brk_sel;
          state_nxt        = hbpwm_pkg::ST_MUL;
        end
      end
      hbpwm_pkg::ST_MUL: begin
        if (mul_done) begin
          saved_duty_nxt[m] = raw_r;
          brake_flag_nxt[m] = brk_r;
          sh_fwd_nxt[m]     = (brk_r || !raw_r[15]) ? mul_c : '0;
          sh_rev_nxt[m]     = (brk_r || raw_r[15]) ? mul_c : '0;
          state_nxt         = hbpwm_pkg::ST_DONE;
        end
      end
      hbpwm_pkg::ST_DONE: begin
        // load the result once the output register is free or being taken
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = status_r;
          out_data_nxt  = {lv_period_r[1], lv_rev_r[1], lv_fwd_r[1],
                           lv_period_r[0], lv_rev_r[0], lv_fwd_r[0]};
          state_nxt     = hbpwm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hbpwm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hbpwm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      status_r    <= 1'b0;
      max_duty_r  <= hbpwm_pkg::ResetMaxDuty;
      min_freq_r  <= hbpwm_pkg::ResetMinFreq;
      max_freq_r  <= hbpwm_pkg::ResetMaxFreq;
      timer_clk_r <= hbpwm_pkg::ResetTimerClk;
      for (int i = 0; i < 2; i++) begin
        saved_duty_r[i] <= '0;
        brake_flag_r[i] <= 1'b0;
        sh_period_r[i]  <= hbpwm_pkg::ResetPeriod;
        sh_fwd_r[i]     <= '0;
        sh_rev_r[i]     <= '0;
        lv_period_r[i]  <= hbpwm_pkg::ResetPeriod;
        lv_fwd_r[i]     <= '0;
        lv_rev_r[i]     <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      status_r     <= status_nxt;
      saved_duty_r <= saved_duty_nxt;
      brake_flag_r <= brake_flag_nxt;
      sh_period_r  <= sh_period_nxt;
      sh_fwd_r     <= sh_fwd_nxt;
      sh_rev_r     <= sh_rev_nxt;
      lv_period_r  <= lv_period_nxt;
      lv_fwd_r     <= lv_fwd_nxt;
      lv_rev_r     <= lv_rev_nxt;
      if (cfg_wr_en) begin
        case (hbpwm_pkg::cfg_idx_t'(cfg_addr))
          hbpwm_pkg::CFG_MAX_DUTY:  max_duty_r  <= cfg_wdata[hbpwm_pkg::MagW-1:0];
          hbpwm_pkg::CFG_MIN_FREQ:  min_freq_r  <= cfg_wdata[hbpwm_pkg::FreqW-1:0];
          hbpwm_pkg::CFG_MAX_FREQ:  max_freq_r  <= cfg_wdata[hbpwm_pkg::FreqW-1:0];
          hbpwm_pkg::CFG_TIMER_CLK: timer_clk_r <= cfg_wdata[hbpwm_pkg::ClockW-1:0];
          default: ;
        endcase
      end
    end
    // payload registers
    cmd_r      <= cmd_nxt;
    raw_r      <= raw_nxt;
    brk_r      <= brk_nxt;
    out_data_r <= out_data_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

endmodule

// ----- rtl/hbpwm_chk.sv -----
// port-level checker for the dual h-bridge pwm compare calculator, with its bind
module hbpwm_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [95:0]                    out_tdata,
  input logic                           out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one command at a time: no second transfer right after one
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command taken while busy");

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_tvalid)
    else $error("result present after reset");

  // a new result never appears the cycle after a command transfer
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result too early");

endmodule

bind dual_hbridge_pwm_compare_calc hbpwm_chk u_hbpwm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the dual h-bridge pwm compare calculator
module tb_top;
  import hbpwm_pkg::*;

  // run shape
  localparam int LimitCycles  = 400000;  // several times the slowest correct run
  localparam int SettleCycles = 60;      // longer than a shift command's latency
  localparam int Phases       = 5;
  localparam int PhaseItems   = 206;

  // motor selector values; 0 and 3 select no motor
  localparam logic [1:0] MOTOR_NONE  = 2'd0;
  localparam logic [1:0] MOTOR_ONE   = 2'd1;
  localparam logic [1:0] MOTOR_TWO   = 2'd2;
  localparam logic [1:0] MOTOR_SPARE = 2'd3;

  // result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // one result transfer as seen on the result channel
  typedef struct packed {
    logic        status;
    logic [15:0] m1_fwd;
    logic [15:0] m1_rev;
    logic [15:0] m1_period;
    logic [15:0] m2_fwd;
    logic [15:0] m2_rev;
    logic [15:0] m2_period;
  } live_regs_t;

  // one row of the directed part: a register write or a command
  typedef struct {
    bit          is_cfg;
    cfg_idx_t    idx;
    logic [23:0] wdata;
    cmd_t        cmd;
    bit          typed;   // want holds the result typed in by hand
    live_regs_t  want;
  } step_row_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                cfg_wr_en  = 1'b0;
  logic [CfgIdxW-1:0]  cfg_addr   = '0;
  logic [CfgDataW-1:0] cfg_wdata  = '0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [31:0]         in_tdata   = '0;  // duty[15:0], frequency[31:16]
  logic [3:0]          in_tuser   = '0;  // func[1:0], motor[3:2]
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [95:0]         out_tdata;        // m1_fwd, m1_rev, m1_period, m2_fwd, m2_rev, m2_period
  logic                out_tuser;        // status

  dual_hbridge_pwm_compare_calc DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int         errors       = 0;
  int         cycle_count  = 0;
  bit         in_idle_en   = 1'b0;
  bit         out_stall_en = 1'b0;
  live_regs_t pending_regs[$];  // results still owed by the block, oldest first
  step_row_t  steps[$];

  // predictor copy of the configuration registers
  logic [14:0] lim_duty;
  logic [15:0] lo_freq;
  logic [15:0] hi_freq;
  logic [23:0] tick_clk;

  // predictor copy of the per-motor state, index 0 is motor one
  logic [15:0] duty_mem[2];
  logic        brake_mem[2];
  logic [15:0] sh_period[2];
  logic [15:0] sh_fwd[2];
  logic [15:0] sh_rev[2];
  logic [15:0] lv_period[2];
  logic [15:0] lv_fwd[2];
  logic [15:0] lv_rev[2];

  function automatic void reset_predictor();
    lim_duty = ResetMaxDuty;
    lo_freq  = ResetMinFreq;
    hi_freq  = ResetMaxFreq;
    tick_clk = ResetTimerClk;
    for (int i = 0; i < 2; i++) begin
      duty_mem[i]  = '0;
      brake_mem[i] = 1'b0;
      sh_period[i] = ResetPeriod;
      sh_fwd[i]    = '0;
      sh_rev[i]    = '0;
      lv_period[i] = ResetPeriod;
      lv_fwd[i]    = '0;
      lv_rev[i]    = '0;
    end
  endfunction

  // period times limited magnitude, Q1.15 product truncated back to counts
  function automatic logic [15:0] scaled_compare(logic [15:0] period, logic [16:0] mag);
    logic [16:0] lim;
    logic [31:0] prod;
    lim  = (mag > {2'b00, lim_duty}) ? {2'b00, lim_duty} : mag;
    prod = {16'd0, period} * {15'd0, lim};
    return prod[30:15];
  endfunction

  // sign picks the leg; the most negative duty has magnitude 32768
  function automatic void load_duty(int m, logic [15:0] raw);
    logic [16:0] mag;
    logic [15:0] cmp;
    mag          = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    cmp          = scaled_compare(sh_period[m], mag);
    duty_mem[m]  = raw;
    brake_mem[m] = 1'b0;
    sh_fwd[m]    = raw[15] ? 16'd0 : cmp;
    sh_rev[m]    = raw[15] ? cmp : 16'd0;
  endfunction

  // both legs the same, negative duty taken as zero but kept raw
  function automatic void load_brake(int m, logic [15:0] raw);
    logic [15:0] cmp;
    cmp          = scaled_compare(sh_period[m], raw[15] ? 17'd0 : {1'b0, raw});
    duty_mem[m]  = raw;
    brake_mem[m] = 1'b1;
    sh_fwd[m]    = cmp;
    sh_rev[m]    = cmp;
  endfunction

  // works out the live registers and status after one command
  task automatic predict_live_regs(input cmd_t c, output live_regs_t r);
    logic        ok_motor;
    int          m;
    logic [23:0] p;
    ok_motor = (c.motor == MOTOR_ONE) || (c.motor == MOTOR_TWO);
    m        = (c.motor == MOTOR_TWO) ? 1 : 0;
    r.status = STATUS_OK;
    case (c.func)
      FUNC_DUTY: begin
        if (ok_motor) load_duty(m, c.duty);
      end
      FUNC_BRAKE: begin
        if (ok_motor) load_brake(m, c.duty);
      end
      FUNC_SHIFT: begin
        // zero is refused even if the lower bound allows it
        if (c.freq == 16'd0 || c.freq < lo_freq || c.freq > hi_freq || !ok_motor) begin
          r.status = STATUS_BAD;
        end else begin
          p            = tick_clk / {8'd0, c.freq};
          sh_period[m] = (p > 24'h00FFFF) ? 16'hFFFF : p[15:0];
          // the motor's own brake flag picks the rule for the recompute
          if (brake_mem[m]) load_brake(m, duty_mem[m]);
          else load_duty(m, duty_mem[m]);
        end
      end
      default: begin
        // apply ignores the motor field and copies both motors
        for (int i = 0; i < 2; i++) begin
          lv_fwd[i]    = sh_fwd[i];
          lv_rev[i]    = sh_rev[i];
          lv_period[i] = sh_period[i];
        end
      end
    endcase
    r.m1_fwd    = lv_fwd[0];
    r.m1_rev    = lv_rev[0];
    r.m1_period = lv_period[0];
    r.m2_fwd    = lv_fwd[1];
    r.m2_rev    = lv_rev[1];
    r.m2_period = lv_period[1];
  endtask

  function automatic live_regs_t regs_of(logic st, logic [15:0] f1, logic [15:0] r1,
                                         logic [15:0] p1, logic [15:0] f2,
                                         logic [15:0] r2, logic [15:0] p2);
    live_regs_t r;
    r = '{status: st, m1_fwd: f1, m1_rev: r1, m1_period: p1,
          m2_fwd: f2, m2_rev: r2, m2_period: p2};
    return r;
  endfunction

  function automatic void add_cmd(func_t f, logic [1:0] mo, logic [15:0] d, logic [15:0] fr,
                                  bit typed = 1'b0, live_regs_t w = '0);
    step_row_t row;
    row.is_cfg = 1'b0;
    row.idx    = CFG_MAX_DUTY;
    row.wdata  = '0;
    row.cmd    = '{func: f, motor: mo, duty: d, freq: fr};
    row.typed  = typed;
    row.want   = w;
    steps.push_back(row);
  endfunction

  function automatic void add_cfg(cfg_idx_t i, logic [23:0] v);
    step_row_t row;
    row.is_cfg = 1'b1;
    row.idx    = i;
    row.wdata  = v;
    row.cmd    = '0;
    row.typed  = 1'b0;
    row.want   = '0;
    steps.push_back(row);
  endfunction

  // random command with in-range frequencies most of the time so shifts get through
  function automatic cmd_t random_cmd();
    cmd_t c;
    c.func = func_t'($urandom_range(0, 3));
    if ($urandom_range(0, 7) == 0) c.motor = 2'($urandom_range(0, 3));
    else c.motor = $urandom_range(0, 1) ? MOTOR_TWO : MOTOR_ONE;
    case ($urandom_range(0, 11))
      0:       c.duty = 16'h8000;
      1:       c.duty = 16'h7FFF;
      2:       c.duty = 16'h0000;
      default: c.duty = 16'($urandom_range(0, 65535));
    endcase
    if ($urandom_range(0, 3) != 0) c.freq = 16'($urandom_range(lo_freq, hi_freq));
    else c.freq = 16'($urandom_range(0, 65535));
    return c;
  endfunction

  // offers one command, waits for the transfer, then records what the block owes
  task automatic push_cmd(input cmd_t c, input bit typed, input live_regs_t want);
    live_regs_t predicted;
    if (in_idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {c.motor, c.func};
    in_tdata  <= {c.freq, c.duty};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_live_regs(c, predicted);
    pending_regs.push_back(typed ? want : predicted);
  endtask

  // drains every owed result, then lets the block fall idle
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_regs.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [23:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_MAX_DUTY: lim_duty = val[14:0];
      CFG_MIN_FREQ: lo_freq  = val[15:0];
      CFG_MAX_FREQ: hi_freq  = val[15:0];
      default:      tick_clk = val;
    endcase
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // result side back-pressure: short stalls in bursts, none when disabled
  initial begin
    @(posedge clk);
    forever begin
      if (out_stall_en && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // every result transfer is matched against the oldest owed result
  always @(posedge clk) begin : result_check
    live_regs_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_regs.size() == 0) begin
        $display("%0t: result transfer with nothing expected, actual status %0d", $time,
                 out_tuser);
        errors++;
      end else begin
        want = pending_regs.pop_front();
        check_field("status", {15'd0, want.status}, {15'd0, out_tuser});
        check_field("m1_fwd_compare", want.m1_fwd, out_tdata[15:0]);
        check_field("m1_rev_compare", want.m1_rev, out_tdata[31:16]);
        check_field("m1_period", want.m1_period, out_tdata[47:32]);
        check_field("m2_fwd_compare", want.m2_fwd, out_tdata[63:48]);
        check_field("m2_rev_compare", want.m2_rev, out_tdata[79:64]);
        check_field("m2_period", want.m2_period, out_tdata[95:80]);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LimitCycles) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    live_regs_t  reset_view;
    live_regs_t  full_view;
    live_regs_t  bad_view;
    logic [14:0] md;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [23:0] tc;
    bit          last_cfg;

    reset_predictor();

    // hand-typed results for the opening rows
    reset_view = regs_of(STATUS_OK, 16'd0, 16'd0, 16'd40000, 16'd0, 16'd0, 16'd40000);
    // full duty on a 40000 period: 40000 * 32767 >> 15
    full_view  = regs_of(STATUS_OK, 16'd39998, 16'd0, 16'd40000, 16'd0, 16'd39998, 16'd40000);
    bad_view   = full_view;
    bad_view.status = STATUS_BAD;

    // live registers straight after reset
    add_cmd(FUNC_APPLY, MOTOR_NONE, 16'h0000, 16'd0, 1'b1, reset_view);
    // full forward and most negative duty, still in the shadows only
    add_cmd(FUNC_DUTY, MOTOR_ONE, 16'h7FFF, 16'd0, 1'b1, reset_view);
    add_cmd(FUNC_DUTY, MOTOR_TWO, 16'h8000, 16'd0, 1'b1, reset_view);
    // apply with an unused motor field copies both motors
    add_cmd(FUNC_APPLY, MOTOR_SPARE, 16'hFFFF, 16'hFFFF, 1'b1, full_view);
    // bad motor on duty and brake is ignored quietly
    add_cmd(FUNC_DUTY, MOTOR_NONE, 16'h1234, 16'd500, 1'b1, full_view);
    add_cmd(FUNC_BRAKE, MOTOR_SPARE, 16'h4321, 16'd500, 1'b1, full_view);
    // shift refusals: bad motor, zero, below and above the limits
    add_cmd(FUNC_SHIFT, MOTOR_NONE, 16'h0000, 16'd1000, 1'b1, bad_view);
    add_cmd(FUNC_SHIFT, MOTOR_ONE, 16'h0000, 16'd0, 1'b1, bad_view);
    add_cmd(FUNC_SHIFT, MOTOR_ONE, 16'h0000, 16'd61, 1'b1, bad_view);
    add_cmd(FUNC_SHIFT, MOTOR_ONE, 16'h0000, 16'd20001, 1'b1, bad_view);
    // accepted shifts at both limits recompute from the saved duty
    add_cmd(FUNC_SHIFT, MOTOR_ONE, 16'h0000, 16'd62);
    add_cmd(FUNC_SHIFT, MOTOR_TWO, 16'h0000, 16'd20000);
    // negative brake counts as zero, full brake
    add_cmd(FUNC_BRAKE, MOTOR_ONE, 16'hFFFF, 16'd0);
    add_cmd(FUNC_BRAKE, MOTOR_TWO, 16'h7FFF, 16'd0);
    add_cmd(FUNC_APPLY, MOTOR_ONE, 16'h0000, 16'd0);
    add_cmd(FUNC_SHIFT, MOTOR_ONE, 16'h0000, 16'hFFFF);
    // zero duty limit, fastest timer clock, widest frequency window
    add_cfg(CFG_MAX_DUTY, 24'd0);
    add_cfg(CFG_TIMER_CLK, 24'd16000000);
    add_cfg(CFG_MIN_FREQ, 24'd0);
    add_cfg(CFG_MAX_FREQ, 24'd65535);
    add_cmd(FUNC_DUTY, MOTOR_ONE, 16'h4000, 16'd0);
    // period saturates at the top of the counter
    add_cmd(FUNC_SHIFT, MOTOR_ONE, 16'h0000, 16'd1);
    // zero frequency refused with the lower bound at zero
    add_cmd(FUNC_SHIFT, MOTOR_TWO, 16'h0000, 16'd0);
    add_cmd(FUNC_BRAKE, MOTOR_TWO, 16'h7FFF, 16'd0);
    add_cmd(FUNC_APPLY, MOTOR_TWO, 16'h0000, 16'd0);
    // timer clock below the frequency gives a zero period
    add_cfg(CFG_TIMER_CLK, 24'd1);
    add_cfg(CFG_MAX_DUTY, 24'd32767);
    add_cmd(FUNC_SHIFT, MOTOR_TWO, 16'h0000, 16'd2);
    add_cmd(FUNC_DUTY, MOTOR_ONE, 16'h8001, 16'd0);
    add_cmd(FUNC_APPLY, MOTOR_NONE, 16'h0000, 16'd0);

    // synchronous reset, held low from the start and then released
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_en   = 1'b1;
    out_stall_en = 1'b1;

    // directed part; register writes only once the block is idle
    last_cfg = 1'b0;
    foreach (steps[k]) begin
      if (steps[k].is_cfg) begin
        if (!last_cfg) settle();
        write_reg(steps[k].idx, steps[k].wdata);
      end else begin
        push_cmd(steps[k].cmd, steps[k].typed, steps[k].want);
      end
      last_cfg = steps[k].is_cfg;
    end

    // random part, one register setting per phase
    for (int ph = 0; ph < Phases; ph++) begin
      settle();
      // the last phase runs flat out on both sides
      if (ph == Phases - 1) begin
        in_idle_en   = 1'b0;
        out_stall_en = 1'b0;
      end
      case (ph)
        0: begin
          md = 15'h7FFF;
          lo = 16'd1;
          hi = 16'hFFFF;
          tc = 24'd16000000;
        end
        1: begin
          // no duty headroom, tiny periods including zero
          md = 15'd0;
          lo = 16'd1;
          hi = 16'd40;
          tc = 24'($urandom_range(1, 200));
        end
        default: begin
          md = 15'($urandom_range(0, 32767));
          lo = 16'($urandom_range(1, 2000));
          hi = 16'($urandom_range(lo, 65535));
          tc = 24'($urandom_range(1, 16000000));
        end
      endcase
      write_reg(CFG_MAX_DUTY, {9'd0, md});
      write_reg(CFG_MIN_FREQ, {8'd0, lo});
      write_reg(CFG_MAX_FREQ, {8'd0, hi});
      write_reg(CFG_TIMER_CLK, tc);
      repeat (PhaseItems) push_cmd(random_cmd(), 1'b0, '0);
    end

    settle();
    if (errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
